// ===== sv/nqsc_pkg.sv =====
// shared constants and types for the n-queens solution counter
`default_nettype none

package nqsc_pkg;

    localparam int MAX_QUEENS = 8;

    localparam int ROW_W  = $clog2(MAX_QUEENS);
    localparam int COL_W  = $clog2(MAX_QUEENS + 1);
    localparam int FIRST_W = 3;
    localparam int SIZE_W  = 4;
    localparam int CNT_W   = 16;

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [COL_W-1:0] col_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== sv/nqsc_check.sv =====
// shared attack compare unit: one earlier queen against the trial row
`default_nettype none

module nqsc_check (
    input  wire nqsc_pkg::row_t queen_row,
    input  wire nqsc_pkg::row_t trial_row,
    input  wire nqsc_pkg::col_t distance,
    output logic               conflict
);
    import nqsc_pkg::*;

    row_t diff;

    always_comb
    begin
        if (queen_row > trial_row)
        begin
            diff = queen_row - trial_row;
        end
        else
        begin
            diff = trial_row - queen_row;
        end
        conflict = (queen_row == trial_row) || (COL_W'(diff) == distance);
    end

endmodule

`default_nettype wire

// ===== sv/n_queens_solution_counter_core.sv =====
// n-queens solution counter: backtracking sequencer around one shared compare unit
//
// usage
//   config: board_size is written with a cfg_valid/cfg_ready transfer; cfg_ready is
//   always high. sizes above the board maximum act as the maximum, zero rejects all.
//   command: a transfer happens when start is high and busy is low; first_row is
//   the row of the queen in column zero and is sampled at that edge.
//   result: done is high for exactly one cycle with solutions and bad_row valid.
//   the receiver cannot stall; the result is taken in the done cycle.
// latency
//   a bad first row gives done in the cycle right after the command transfer.
//   otherwise each search step passes through the step state, then the check state
//   once per earlier queen compared by the shared attack unit (one compare per cycle);
//   the total time per item is set by the partial placements tried.
//   busy stays high from the command transfer through the done cycle, so one
//   item is in flight at a time.
// reset
//   rst_n low clears the sequencer, the try stack and sets board_size to eight.
`default_nettype none

module n_queens_solution_counter_core (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire [nqsc_pkg::SIZE_W-1:0]  board_size,
    input  wire                     start,
    output logic                    busy,
    input  wire [nqsc_pkg::FIRST_W-1:0] first_row,
    output logic                    done,
    output logic [nqsc_pkg::CNT_W-1:0]  solutions,
    output logic                    bad_row
);
    import nqsc_pkg::*;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] size_reg;
    col_t n_reg, n_next;
    col_t col_reg, col_next;
    row_t idx_reg, idx_next;
    row_t trial_reg, trial_next;
    cnt_t count_reg, count_next;
    logic bad_reg, bad_next;

    row_t queen_row_reg [MAX_QUEENS];
    col_t try_row_reg [MAX_QUEENS];

    logic q_we;
    row_t q_waddr;
    row_t q_wdata;
    logic t_we;
    row_t t_waddr;
    col_t t_wdata;

    col_t n_eff;
    col_t first_ext;
    logic first_bad;
    row_t col_idx;
    col_t cur_try;
    logic at_end;
    logic exhausted;
    col_t col_dec;
    logic back_to_zero;
    logic last_idx;
    col_t distance;
    logic conflict;

    nqsc_check u_check (
        .queen_row (queen_row_reg[idx_reg]),
        .trial_row (trial_reg),
        .distance  (distance),
        .conflict  (conflict)
    );

    // search decisions
    always_comb
    begin
        if (size_reg > SIZE_W'(MAX_QUEENS))
        begin
            n_eff = COL_W'(MAX_QUEENS);
        end
        else
        begin
            n_eff = COL_W'(size_reg);
        end
        first_ext    = COL_W'(first_row);
        first_bad    = first_ext >= n_eff;
        col_idx      = col_reg[ROW_W-1:0];
        cur_try      = try_row_reg[col_idx];
        at_end       = col_reg >= n_reg;
        exhausted    = cur_try >= n_reg;
        col_dec      = col_reg - 1'b1;
        back_to_zero = col_dec == '0;
        last_idx     = (COL_W'(idx_reg) + 1'b1) == col_reg;
        distance     = col_reg - COL_W'(idx_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = first_bad ? ST_DONE : ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (at_end || exhausted)
                begin
                    state_next = back_to_zero ? ST_DONE : ST_STEP;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (conflict || last_idx)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        n_next     = n_reg;
        col_next   = col_reg;
        idx_next   = idx_reg;
        trial_next = trial_reg;
        count_next = count_reg;
        bad_next   = bad_reg;
        q_we       = 1'b0;
        q_waddr    = '0;
        q_wdata    = '0;
        t_we       = 1'b0;
        t_waddr    = '0;
        t_wdata    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = n_eff;
                    count_next = '0;
                    bad_next   = first_bad;
                    col_next   = COL_W'(1);
                    if (!first_bad)
                    begin
                        q_we    = 1'b1;
                        q_waddr = '0;
                        q_wdata = ROW_W'(first_row);
                        t_we    = COL_W'(1) < n_eff;
                        t_waddr = ROW_W'(1);
                    end
                end
            end
            ST_STEP:
            begin
                if (at_end)
                begin
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    col_next = col_dec;
                end
                else if (exhausted)
                begin
                    col_next = col_dec;
                end
                else
                begin
                    t_we       = 1'b1;
                    t_waddr    = col_idx;
                    t_wdata    = cur_try + 1'b1;
                    trial_next = cur_try[ROW_W-1:0];
                    idx_next   = '0;
                end
            end
            ST_CHECK:
            begin
                if (!conflict)
                begin
                    if (last_idx)
                    begin
                        q_we     = 1'b1;
                        q_waddr  = col_idx;
                        q_wdata  = trial_reg;
                        col_next = col_reg + 1'b1;
                        t_we     = (col_reg + 1'b1) < n_reg;
                        t_waddr  = col_idx + 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = state_reg != ST_IDLE;
        done      = state_reg == ST_DONE;
        solutions = count_reg;
        bad_row   = bad_reg;
        cfg_ready = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            size_reg  <= SIZE_W'(MAX_QUEENS);
            n_reg     <= '0;
            col_reg   <= '0;
            count_reg <= '0;
            bad_reg   <= 1'b0;
            for (int k = 0; k < MAX_QUEENS; k++)
            begin
                try_row_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            col_reg   <= col_next;
            count_reg <= count_next;
            bad_reg   <= bad_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= board_size;
            end
            if (t_we)
            begin
                try_row_reg[t_waddr] <= t_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        trial_reg <= trial_next;
        if (q_we)
        begin
            queen_row_reg[q_waddr] <= q_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== sv/nqsc_checker.sv =====
// port-level checks for the n-queens solution counter, bound to the top level
`default_nettype none

module nqsc_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          start,
    input wire                          busy,
    input wire                          done,
    input wire [nqsc_pkg::CNT_W-1:0]    solutions,
    input wire                          bad_row
);
    import nqsc_pkg::*;

    // a command transfer makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    // a result only appears while a command is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe without a command in flight");

    // one result per command, then ready again
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not followed by idle");

    // rejected first row carries a zero count
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_row) |-> (solutions == '0))
        else $error("nonzero count with bad first row");

endmodule

bind n_queens_solution_counter_core nqsc_checker u_nqsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .solutions (solutions),
    .bad_row   (bad_row)
);

`default_nettype wire

// ===== test/n_queens_solution_counter_core_tb.sv =====
// testbench for the n-queens solution counter: directed board table, then random board phases
`default_nettype none

module n_queens_solution_counter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nqsc_pkg::*;

    typedef struct packed {
        cnt_t count;
        logic bad;
    } tally_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [FIRST_W-1:0] row;
        logic               known;
        cnt_t               count;
        logic               bad;
    } board_case_t;

    localparam int N_CASES = 22;
    localparam int N_ITEMS = 300;
    localparam int IDLE_PCT = 29;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [SIZE_W-1:0]  board_size;
    logic               start;
    logic               busy;
    logic [FIRST_W-1:0] first_row;
    logic               done;
    cnt_t               solutions;
    logic               bad_row;

    tally_t            expected_tallies[$];
    logic [SIZE_W-1:0] size_reg;
    int                mismatches = 0;
    int                items_sent = 0;
    bit                idle_en = 1'b1;

    // size, first row, known, count, bad
    board_case_t board_cases [N_CASES] = '{
        '{4'd8,  3'd0, 1'b1, 16'd4, 1'b0},
        '{4'd8,  3'd7, 1'b1, 16'd4, 1'b0},
        '{4'd8,  3'd3, 1'b0, 16'd0, 1'b0},
        '{4'd1,  3'd0, 1'b1, 16'd1, 1'b0},
        '{4'd1,  3'd7, 1'b1, 16'd0, 1'b1},
        '{4'd1,  3'd1, 1'b1, 16'd0, 1'b1},
        '{4'd0,  3'd0, 1'b1, 16'd0, 1'b1},
        '{4'd0,  3'd7, 1'b1, 16'd0, 1'b1},
        '{4'd2,  3'd0, 1'b0, 16'd0, 1'b0},
        '{4'd2,  3'd1, 1'b0, 16'd0, 1'b0},
        '{4'd2,  3'd2, 1'b1, 16'd0, 1'b1},
        '{4'd3,  3'd1, 1'b0, 16'd0, 1'b0},
        '{4'd3,  3'd2, 1'b0, 16'd0, 1'b0},
        '{4'd4,  3'd1, 1'b0, 16'd0, 1'b0},
        '{4'd4,  3'd0, 1'b0, 16'd0, 1'b0},
        '{4'd5,  3'd5, 1'b1, 16'd0, 1'b1},
        '{4'd5,  3'd2, 1'b0, 16'd0, 1'b0},
        '{4'd15, 3'd7, 1'b1, 16'd4, 1'b0},
        '{4'd15, 3'd3, 1'b0, 16'd0, 1'b0},
        '{4'd9,  3'd0, 1'b1, 16'd4, 1'b0},
        '{4'd6,  3'd4, 1'b0, 16'd0, 1'b0},
        '{4'd8,  3'd4, 1'b0, 16'd0, 1'b0}
    };

    n_queens_solution_counter_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .board_size (board_size),
        .start      (start),
        .busy       (busy),
        .first_row  (first_row),
        .done       (done),
        .solutions  (solutions),
        .bad_row    (bad_row)
    );

    always #5 clk = ~clk;

    // depth-first placement count with the first queen fixed
    function automatic tally_t predict_count(input logic [SIZE_W-1:0] size,
                                             input logic [FIRST_W-1:0] first);
        int     n;
        int     col;
        int     r;
        int     gap;
        int     found;
        int     placed [MAX_QUEENS];
        int     trial [MAX_QUEENS + 1];
        bit     free;
        tally_t res;
        n = (size > MAX_QUEENS) ? MAX_QUEENS : int'(size);
        res.count = '0;
        res.bad = (int'(first) >= n);
        if (res.bad)
            return res;
        placed[0] = first;
        col = 1;
        trial[1] = 0;
        found = 0;
        while (col >= 1)
        begin
            if (col >= n)
            begin
                if (found < 65535)
                    found++;
                col--;
            end
            else if (trial[col] >= n)
                col--;
            else
            begin
                r = trial[col];
                trial[col]++;
                free = 1'b1;
                for (int k = 0; k < col; k++)
                begin
                    gap = (placed[k] > r) ? placed[k] - r : r - placed[k];
                    if (placed[k] == r || gap == col - k)
                        free = 1'b0;
                end
                if (free)
                begin
                    placed[col] = r;
                    col++;
                    if (col < n)
                        trial[col] = 0;
                end
            end
        end
        res.count = cnt_t'(found);
        return res;
    endfunction

    function automatic bit idle_roll();
        return idle_en && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // start stays high after the transfer; the next call or a size write sets it
    task automatic issue_row(input logic [FIRST_W-1:0] row, input tally_t want);
        bit taken;
        bit idle;
        taken = 1'b0;
        idle = idle_roll();
        start <= !idle;
        first_row <= idle ? FIRST_W'($urandom) : row;
        while (!taken)
        begin
            @(posedge clk);
            if (start && !busy)
                taken = 1'b1;
            else
            begin
                idle = idle_roll();
                start <= !idle;
                first_row <= idle ? FIRST_W'($urandom) : row;
            end
        end
        expected_tallies.push_back(want);
        items_sent++;
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        bit taken;
        taken = 1'b0;
        start <= 1'b0;
        while (expected_tallies.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        board_size <= value;
        while (!taken)
        begin
            @(posedge clk);
            taken = cfg_valid && cfg_ready;
        end
        cfg_valid <= 1'b0;
        size_reg = value;
    endtask

    always @(posedge clk)
    begin
        tally_t want;
        if (rst_n && done)
        begin
            if (expected_tallies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: solutions %0d bad_row %0b", solutions, bad_row);
            end
            else
            begin
                want = expected_tallies.pop_front();
                if (solutions !== want.count || bad_row !== want.bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: solutions exp %0d got %0d, bad_row exp %0b got %0b",
                                 want.count, solutions, want.bad, bad_row);
                end
            end
        end
    end

    initial
    begin
        tally_t             want;
        int                 n_lim;
        int                 phase_no;
        int                 pick;
        logic [SIZE_W-1:0]  size_pick;
        logic [FIRST_W-1:0] row_pick;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        board_size <= SIZE_W'(MAX_QUEENS);
        start <= 1'b0;
        first_row <= '0;
        size_reg = SIZE_W'(MAX_QUEENS);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (board_cases[i])
        begin
            if (board_cases[i].size != size_reg)
                write_size(board_cases[i].size);
            if (board_cases[i].known)
                want = '{board_cases[i].count, board_cases[i].bad};
            else
                want = predict_count(size_reg, board_cases[i].row);
            issue_row(board_cases[i].row, want);
        end

        // mostly small boards, a few full-size and oversized ones
        phase_no = 0;
        while (items_sent < N_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                size_pick = '0;
            else if (pick < 60)
                size_pick = SIZE_W'($urandom_range(1, 6));
            else if (pick < 78)
                size_pick = SIZE_W'(7);
            else if (pick < 90)
                size_pick = SIZE_W'(8);
            else
                size_pick = SIZE_W'($urandom_range(9, 15));
            idle_en = (phase_no < 6 || phase_no >= 10);
            write_size(size_pick);
            n_lim = (size_pick > MAX_QUEENS) ? MAX_QUEENS : int'(size_pick);
            repeat ($urandom_range(4, 16))
            begin
                if (n_lim == 0 || $urandom_range(0, 99) < 15)
                    row_pick = FIRST_W'($urandom_range(0, 7));
                else
                    row_pick = FIRST_W'($urandom_range(0, n_lim - 1));
                issue_row(row_pick, predict_count(size_reg, row_pick));
            end
            phase_no++;
        end
        start <= 1'b0;

        while (expected_tallies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_tallies.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
